FILE: rtl/core/das_pkg.sv
// ============================================================================
// das_pkg: shared types and codes of the door actuator sequencer
// Item and result structs, event codes, door phase and lamp codes, queue sizes.
// ============================================================================
package das_pkg;

    // door phases
    localparam logic [2:0] PH_UNKNOWN = 3'd0;
    localparam logic [2:0] PH_OPENED  = 3'd1;
    localparam logic [2:0] PH_CLOSED  = 3'd2;
    localparam logic [2:0] PH_OPENING = 3'd3;
    localparam logic [2:0] PH_CLOSING = 3'd4;

    // lamp modes
    localparam logic [1:0] LAMP_OFF   = 2'd0;
    localparam logic [1:0] LAMP_ON    = 2'd1;
    localparam logic [1:0] LAMP_BLINK = 2'd2;

    // door events
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_OPEN     = 3'd1;
    localparam logic [2:0] EV_CLOSE    = 3'd2;
    localparam logic [2:0] EV_IS_UP    = 3'd3;
    localparam logic [2:0] EV_IS_DOWN  = 3'd4;
    localparam logic [2:0] EV_MOV_UP   = 3'd5;
    localparam logic [2:0] EV_MOV_DOWN = 3'd6;
    localparam logic [2:0] EV_TIMEOUT  = 3'd7;

    // configuration register indexes
    localparam int          CFG_IW             = 2;
    localparam logic [1:0]  CFG_MOVE_START     = 2'd0;
    localparam logic [1:0]  CFG_MOVE_FINISH    = 2'd1;
    localparam logic [15:0] MOVE_START_RESET   = 16'd30;
    localparam logic [15:0] MOVE_FINISH_RESET  = 16'd80;

    // queue sizes (depth 2, one pointer bit, count up to 2)
    localparam int        QUEUE_DEPTH = 2;
    localparam int        QUEUE_AW    = 1;
    localparam int        QUEUE_CW    = 2;
    localparam logic [1:0] QUEUE_FULL_CNT = 2'd2;

    typedef struct packed {
        logic command_level;
        logic up_sensor;
        logic down_sensor;
    } t_das_in_s;

    typedef struct packed {
        logic       push_coil;
        logic       pull_coil;
        logic [1:0] opening_lamp;
        logic [1:0] closing_lamp;
        logic [2:0] door_phase;
    } t_das_out_s;

    // events of one tick, as classified by the front part
    typedef struct packed {
        logic [2:0] cmd_ev;
        logic [2:0] sens_ev;
    } t_das_evt_s;

    // write request from the front part into the event queue
    typedef struct packed {
        logic       vld;
        t_das_evt_s evt;
    } t_das_evq_wr_s;

    // status of the event queue seen by the back part
    typedef struct packed {
        logic       vld;
        t_das_evt_s evt;
    } t_das_evq_rd_s;

endpackage

FILE: rtl/core/door_actuator_sequencer_core.sv
// ============================================================================
// door_actuator_sequencer_core: door actuator sequencer top level
// Edge classifier, event queue and door machine with its result queue.
// ============================================================================
// flow: an accepted request is written into the event queue; the door machine
//   takes it from there and writes its result into the result queue (empty low)
// throughput: one request per cycle while neither queue is full;
//   a full result queue holds the door machine until a pop has freed an entry
// reset: synchronous active-low i_rst_n clears both queues, edge history,
//   timer and phase (unknown), and loads the tick registers with 30 and 80
module door_actuator_sequencer_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write port
    input  logic                       i_cfg_we,
    input  logic [das_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [15:0]                i_cfg_data,
    // sample tick requests
    input  logic                       push,
    output logic                       full,
    input  das_pkg::t_das_in_s         i_item,
    // result requests
    output logic                       empty,
    input  logic                       pop,
    output das_pkg::t_das_out_s        o_result
);

    das_pkg::t_das_evq_wr_s evq_wr;
    das_pkg::t_das_evq_rd_s evq_rd;
    logic                   evq_pop;
    logic                   accept;

    // a request is taken whenever the event queue has room
    assign accept = push && !full;

    // front part: level history and edge classification
    das_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_item   (i_item),
        .o_evq_wr (evq_wr)
    );

    // short queue that decouples classification from the door machine
    das_evq u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (evq_wr),
        .i_rd    (evq_pop),
        .o_full  (full),
        .o_rd    (evq_rd)
    );

    // back part: timer, phase machine, coils and lamps, result queue
    das_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_evq       (evq_rd),
        .o_evq_pop   (evq_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule

FILE: rtl/core/das_front.sv
// ============================================================================
// das_front: input edge classifier
// Turns sampled levels into command and sensor events for each accepted tick.
// ============================================================================
module das_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  das_pkg::t_das_in_s     i_item,
    output das_pkg::t_das_evq_wr_s o_evq_wr
);

    logic r_last_cmd;
    logic r_last_up;
    logic r_last_down;
    logic n_last_cmd;
    logic n_last_up;
    logic n_last_down;
    logic up_chg;
    logic down_chg;
    logic cmd_chg;

    assign cmd_chg  = i_item.command_level != r_last_cmd;
    assign up_chg   = i_item.up_sensor != r_last_up;
    assign down_chg = i_item.down_sensor != r_last_down;

    always_comb begin
        o_evq_wr.vld         = i_accept;
        o_evq_wr.evt.cmd_ev  = das_pkg::EV_NONE;
        o_evq_wr.evt.sens_ev = das_pkg::EV_NONE;
        if (cmd_chg) begin
            o_evq_wr.evt.cmd_ev = i_item.command_level ? das_pkg::EV_OPEN : das_pkg::EV_CLOSE;
        end
        // up change wins over down change
        priority if (up_chg) begin
            o_evq_wr.evt.sens_ev = i_item.up_sensor ? das_pkg::EV_IS_UP : das_pkg::EV_MOV_DOWN;
        end else if (down_chg) begin
            o_evq_wr.evt.sens_ev =
                i_item.down_sensor ? das_pkg::EV_MOV_UP : das_pkg::EV_IS_DOWN;
        end else begin
            o_evq_wr.evt.sens_ev = das_pkg::EV_NONE;
        end
    end

    always_comb begin
        n_last_cmd  = r_last_cmd;
        n_last_up   = r_last_up;
        n_last_down = r_last_down;
        if (i_accept) begin
            n_last_cmd = i_item.command_level;
            n_last_up  = i_item.up_sensor;
            // down level only tracked when up held still
            if (!up_chg) begin
                n_last_down = i_item.down_sensor;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cmd  <= 1'b0;
            r_last_up   <= 1'b0;
            r_last_down <= 1'b0;
        end else begin
            r_last_cmd  <= n_last_cmd;
            r_last_up   <= n_last_up;
            r_last_down <= n_last_down;
        end
    end

endmodule

FILE: rtl/core/das_evq.sv
// ============================================================================
// das_evq: event queue
// Two-entry queue of classified events between the front and back parts.
// ============================================================================
module das_evq (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  das_pkg::t_das_evq_wr_s i_wr,
    input  logic                   i_rd,
    output logic                   o_full,
    output das_pkg::t_das_evq_rd_s o_rd
);

    das_pkg::t_das_evt_s              r_mem [das_pkg::QUEUE_DEPTH];
    logic [das_pkg::QUEUE_AW-1:0]     r_wr_ptr;
    logic [das_pkg::QUEUE_AW-1:0]     r_rd_ptr;
    logic [das_pkg::QUEUE_CW-1:0]     r_cnt;
    logic                             do_rd;

    assign o_full   = r_cnt == das_pkg::QUEUE_FULL_CNT;
    assign o_rd.vld = r_cnt != '0;
    assign o_rd.evt = r_mem[r_rd_ptr];
    assign do_rd    = i_rd && o_rd.vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.vld) begin
            r_mem[r_wr_ptr] <= i_wr.evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_wr.vld) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_wr.vld, do_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: rtl/core/das_back.sv
// ============================================================================
// das_back: door machine and result queue
// Runs the timeout timer and the door phase machine, queues one result per tick.
// ============================================================================
module das_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [das_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [15:0]                i_cfg_data,
    input  das_pkg::t_das_evq_rd_s     i_evq,
    output logic                       o_evq_pop,
    input  logic                       i_pop,
    output logic                       o_empty,
    output das_pkg::t_das_out_s        o_result
);

    typedef struct packed {
        logic [2:0]  phase;
        logic [1:0]  coil;
        logic [3:0]  lamp;
        logic [15:0] ticks;
        logic        armed;
    } t_das_st_s;

    function automatic t_das_st_s das_handle(t_das_st_s s, logic [2:0] ev,
                                             logic [15:0] start, logic [15:0] finish);
        t_das_st_s n;
        n = s;
        unique case (s.phase)
            das_pkg::PH_UNKNOWN: begin
                if (ev == das_pkg::EV_IS_UP) begin
                    n.phase = das_pkg::PH_OPENED;
                end else if (ev == das_pkg::EV_IS_DOWN) begin
                    n.phase = das_pkg::PH_CLOSED;
                end
            end
            das_pkg::PH_CLOSED: begin
                if (ev == das_pkg::EV_OPEN) begin
                    n.coil[0]   = 1'b1;
                    n.lamp[1:0] = das_pkg::LAMP_ON;
                    n.ticks     = start;
                    n.armed     = 1'b1;
                    n.phase     = das_pkg::PH_OPENING;
                end
            end
            das_pkg::PH_OPENED: begin
                if (ev == das_pkg::EV_CLOSE) begin
                    n.coil[1]   = 1'b1;
                    n.lamp[3:2] = das_pkg::LAMP_ON;
                    n.ticks     = start;
                    n.armed     = 1'b1;
                    n.phase     = das_pkg::PH_CLOSING;
                end
            end
            das_pkg::PH_OPENING: begin
                if (ev == das_pkg::EV_MOV_UP) begin
                    n.ticks = finish;
                    n.armed = 1'b1;
                end else if (ev == das_pkg::EV_TIMEOUT) begin
                    n.coil[0]   = 1'b0;
                    n.lamp[1:0] = das_pkg::LAMP_BLINK;
                    n.phase     = das_pkg::PH_UNKNOWN;
                end else if (ev == das_pkg::EV_IS_UP) begin
                    n.coil[0]   = 1'b0;
                    n.lamp[1:0] = das_pkg::LAMP_OFF;
                    n.armed     = 1'b0;
                    n.phase     = das_pkg::PH_OPENED;
                end
            end
            das_pkg::PH_CLOSING: begin
                if (ev == das_pkg::EV_MOV_DOWN) begin
                    n.ticks = finish;
                    n.armed = 1'b1;
                end else if (ev == das_pkg::EV_TIMEOUT) begin
                    n.coil[1]   = 1'b0;
                    n.lamp[3:2] = das_pkg::LAMP_BLINK;
                    n.phase     = das_pkg::PH_UNKNOWN;
                end else if (ev == das_pkg::EV_IS_DOWN) begin
                    n.coil[1]   = 1'b0;
                    n.lamp[3:2] = das_pkg::LAMP_OFF;
                    n.armed     = 1'b0;
                    n.phase     = das_pkg::PH_CLOSED;
                end
            end
            default: begin
                n = s;
            end
        endcase
        return n;
    endfunction

    logic [15:0]                  r_move_start_ticks;
    logic [15:0]                  r_move_finish_ticks;
    t_das_st_s                    r_st;
    t_das_st_s                    st_tmr;
    t_das_st_s                    st_cmd;
    t_das_st_s                    n_st;
    das_pkg::t_das_out_s          res;
    das_pkg::t_das_out_s          r_res_mem [das_pkg::QUEUE_DEPTH];
    logic [das_pkg::QUEUE_AW-1:0] r_res_wr_ptr;
    logic [das_pkg::QUEUE_AW-1:0] r_res_rd_ptr;
    logic [das_pkg::QUEUE_CW-1:0] r_res_cnt;
    logic                         res_full;
    logic                         do_pop;

    assign res_full  = r_res_cnt == das_pkg::QUEUE_FULL_CNT;
    assign o_evq_pop = i_evq.vld && !res_full;
    assign o_empty   = r_res_cnt == '0;
    assign o_result  = r_res_mem[r_res_rd_ptr];
    assign do_pop    = i_pop && !o_empty;

    // tick order: timer, then command event, then sensor event
    always_comb begin
        st_tmr = r_st;
        if (r_st.armed) begin
            if (r_st.ticks <= 16'd1) begin
                st_tmr.ticks = '0;
                st_tmr.armed = 1'b0;
                st_tmr = das_handle(st_tmr, das_pkg::EV_TIMEOUT,
                                    r_move_start_ticks, r_move_finish_ticks);
            end else begin
                st_tmr.ticks = r_st.ticks - 16'd1;
            end
        end
        st_cmd = das_handle(st_tmr, i_evq.evt.cmd_ev, r_move_start_ticks, r_move_finish_ticks);
        n_st   = das_handle(st_cmd, i_evq.evt.sens_ev, r_move_start_ticks,
                            r_move_finish_ticks);
    end

    always_comb begin
        res.push_coil    = n_st.coil[0];
        res.pull_coil    = n_st.coil[1];
        res.opening_lamp = n_st.lamp[1:0];
        res.closing_lamp = n_st.lamp[3:2];
        res.door_phase   = n_st.phase;
    end

    always_ff @(posedge i_clk) begin
        if (o_evq_pop) begin
            r_res_mem[r_res_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_move_start_ticks  <= das_pkg::MOVE_START_RESET;
            r_move_finish_ticks <= das_pkg::MOVE_FINISH_RESET;
            r_st                <= '0;
            r_res_wr_ptr        <= '0;
            r_res_rd_ptr        <= '0;
            r_res_cnt           <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == das_pkg::CFG_MOVE_START) begin
                r_move_start_ticks <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == das_pkg::CFG_MOVE_FINISH) begin
                r_move_finish_ticks <= i_cfg_data;
            end
            if (o_evq_pop) begin
                r_st         <= n_st;
                r_res_wr_ptr <= r_res_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_res_rd_ptr <= r_res_rd_ptr + 1'b1;
            end
            unique case ({o_evq_pop, do_pop})
                2'b10:   r_res_cnt <= r_res_cnt + 1'b1;
                2'b01:   r_res_cnt <= r_res_cnt - 1'b1;
                default: r_res_cnt <= r_res_cnt;
            endcase
        end
    end

endmodule

FILE: dv/das_tick_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// das_tick_checker: result checker of the door actuator sequencer
// Watches the config port and both request channels, predicts the door outputs
// of every accepted sample tick and compares them with the popped results.
// ============================================================================
module das_tick_checker
    import das_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_IW-1:0]   i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    input  logic                i_push,
    input  logic                i_full,
    input  t_das_in_s           i_item,
    input  logic                i_empty,
    input  logic                i_pop,
    input  t_das_out_s          i_result,
    output int                  o_fail_count,
    output int                  o_pending
);

    // predicted door state
    logic [15:0] start_ticks;
    logic [15:0] finish_ticks;
    logic [2:0]  phase_now;
    logic        cmd_seen;
    logic        up_seen;
    logic        down_seen;
    logic [15:0] ticks_left;
    logic        timer_on;
    logic        push_on;
    logic        pull_on;
    logic [1:0]  open_lamp;
    logic [1:0]  close_lamp;

    t_das_out_s  door_outputs_q[$];
    int          fail_count = 0;
    int          result_idx = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        $display("[%0t] result %0d: %s", $time, result_idx, msg);
        fail_count++;
    endtask

    task automatic door_event(input logic [2:0] ev);
        case (phase_now)
            PH_UNKNOWN: begin
                if (ev == EV_IS_UP) phase_now = PH_OPENED;
                else if (ev == EV_IS_DOWN) phase_now = PH_CLOSED;
            end
            PH_CLOSED: begin
                if (ev == EV_OPEN) begin
                    push_on    = 1'b1;
                    open_lamp  = LAMP_ON;
                    ticks_left = start_ticks;
                    timer_on   = 1'b1;
                    phase_now  = PH_OPENING;
                end
            end
            PH_OPENED: begin
                if (ev == EV_CLOSE) begin
                    pull_on    = 1'b1;
                    close_lamp = LAMP_ON;
                    ticks_left = start_ticks;
                    timer_on   = 1'b1;
                    phase_now  = PH_CLOSING;
                end
            end
            PH_OPENING: begin
                if (ev == EV_MOV_UP) begin
                    ticks_left = finish_ticks;
                    timer_on   = 1'b1;
                end else if (ev == EV_TIMEOUT) begin
                    push_on   = 1'b0;
                    open_lamp = LAMP_BLINK;
                    phase_now = PH_UNKNOWN;
                end else if (ev == EV_IS_UP) begin
                    push_on   = 1'b0;
                    open_lamp = LAMP_OFF;
                    timer_on  = 1'b0;
                    phase_now = PH_OPENED;
                end
            end
            PH_CLOSING: begin
                if (ev == EV_MOV_DOWN) begin
                    ticks_left = finish_ticks;
                    timer_on   = 1'b1;
                end else if (ev == EV_TIMEOUT) begin
                    pull_on    = 1'b0;
                    close_lamp = LAMP_BLINK;
                    phase_now  = PH_UNKNOWN;
                end else if (ev == EV_IS_DOWN) begin
                    pull_on    = 1'b0;
                    close_lamp = LAMP_OFF;
                    timer_on   = 1'b0;
                    phase_now  = PH_CLOSED;
                end
            end
            default: ;
        endcase
    endtask

    // timeout first, then command edge, then one sensor edge (up wins)
    task automatic predict_door_tick(input t_das_in_s it, output t_das_out_s res);
        if (timer_on) begin
            if (ticks_left <= 16'd1) begin
                ticks_left = '0;
                timer_on   = 1'b0;
                door_event(EV_TIMEOUT);
            end else begin
                ticks_left = ticks_left - 16'd1;
            end
        end
        if (it.command_level != cmd_seen) begin
            cmd_seen = it.command_level;
            door_event(it.command_level ? EV_OPEN : EV_CLOSE);
        end
        if (it.up_sensor != up_seen) begin
            up_seen = it.up_sensor;
            door_event(it.up_sensor ? EV_IS_UP : EV_MOV_DOWN);
        end else if (it.down_sensor != down_seen) begin
            down_seen = it.down_sensor;
            door_event(it.down_sensor ? EV_MOV_UP : EV_IS_DOWN);
        end
        res.push_coil    = push_on;
        res.pull_coil    = pull_on;
        res.opening_lamp = open_lamp;
        res.closing_lamp = close_lamp;
        res.door_phase   = phase_now;
    endtask

    always @(posedge i_clk) begin
        t_das_out_s res;
        t_das_out_s want;
        if (!i_rst_n) begin
            start_ticks  = MOVE_START_RESET;
            finish_ticks = MOVE_FINISH_RESET;
            phase_now    = PH_UNKNOWN;
            cmd_seen     = 1'b0;
            up_seen      = 1'b0;
            down_seen    = 1'b0;
            ticks_left   = '0;
            timer_on     = 1'b0;
            push_on      = 1'b0;
            pull_on      = 1'b0;
            open_lamp    = LAMP_OFF;
            close_lamp   = LAMP_OFF;
            door_outputs_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MOVE_START:  start_ticks  = i_cfg_data;
                    CFG_MOVE_FINISH: finish_ticks = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_push && !i_full) begin
                predict_door_tick(i_item, res);
                door_outputs_q.push_back(res);
            end
            if (i_pop && !i_empty) begin
                if (door_outputs_q.size() == 0) begin
                    report_mismatch("result popped with nothing predicted");
                end else begin
                    want = door_outputs_q.pop_front();
                    if (i_result.push_coil !== want.push_coil)
                        report_mismatch($sformatf("push_coil got %0b want %0b",
                            i_result.push_coil, want.push_coil));
                    if (i_result.pull_coil !== want.pull_coil)
                        report_mismatch($sformatf("pull_coil got %0b want %0b",
                            i_result.pull_coil, want.pull_coil));
                    if (i_result.opening_lamp !== want.opening_lamp)
                        report_mismatch($sformatf("opening_lamp got %0d want %0d",
                            i_result.opening_lamp, want.opening_lamp));
                    if (i_result.closing_lamp !== want.closing_lamp)
                        report_mismatch($sformatf("closing_lamp got %0d want %0d",
                            i_result.closing_lamp, want.closing_lamp));
                    if (i_result.door_phase !== want.door_phase)
                        report_mismatch($sformatf("door_phase got %0d want %0d",
                            i_result.door_phase, want.door_phase));
                end
                result_idx++;
            end
        end
        o_pending <= door_outputs_q.size();
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top: testbench of the door actuator sequencer core
// Drives sample tick requests from a simple door model, with directed edge
// cases first, stalls both queue sides at random and lets the checker judge.
// ============================================================================
module tb_top;
    import das_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;  // cycles with no request moving
    localparam int HOLD_AT        = 200;   // request count that starts the long hold
    localparam int HOLD_CYCLES    = 64;    // receiver hold-off length
    localparam int PRESS_ITEMS    = 80;    // sender runs without gaps this long
    localparam int PHASE_ITEMS    = 96;    // random requests per config setting

    // register slots past the two real ones, writes there must be dropped
    localparam logic [CFG_IW-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_SPARE_HI = 2'd3;

    // door position in the stimulus model
    localparam int POS_DOWN = 0;
    localparam int POS_MID  = 1;
    localparam int POS_UP   = 2;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [15:0]       cfg_data  = '0;
    logic              push      = 1'b0;
    logic              full;
    t_das_in_s         item      = '0;
    logic              empty;
    logic              pop       = 1'b0;
    t_das_out_s        result;

    int   fail_count;
    int   pending;
    int   sent_count  = 0;
    int   idle_cycles = 0;
    bit   tx_calm     = 1'b0;
    bit   rx_calm     = 1'b0;

    // door model state
    int   door_pos  = POS_DOWN;
    logic cmd_lvl   = 1'b0;
    int   move_wait = 0;

    initial begin
        forever #2 clk = ~clk;
    end

    door_actuator_sequencer_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .push        (push),
        .full        (full),
        .i_item      (item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (result)
    );

    das_tick_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_push       (push),
        .i_full       (full),
        .i_item       (item),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_result     (result),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // mostly short gaps, now and then a long one, none while calm
    function automatic int pick_gap(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // offer one sample tick request and hold it until the core takes it;
    // push stays high on return so back-to-back requests need no toggle
    task automatic send_tick(input logic c, input logic u, input logic d);
        int gap;
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        // keep offering while the receiver holds off so the queues back up
        if (sent_count >= HOLD_AT && sent_count < HOLD_AT + PRESS_ITEMS)
            gap = 0;
        else
            gap = pick_gap(tx_calm);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= '{command_level: c, up_sensor: u, down_sensor: d};
        do @(posedge clk); while (full);
        sent_count++;
    endtask

    // stop offering and wait until every predicted result has been popped
    task automatic wait_idle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // both tick registers, then junk into the unused slots
    task automatic load_ticks(input logic [15:0] start_n, input logic [15:0] finish_n);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MOVE_START;
        cfg_data  <= start_n;
        @(posedge clk);
        cfg_index <= CFG_MOVE_FINISH;
        cfg_data  <= finish_n;
        @(posedge clk);
        cfg_index <= CFG_SPARE_LO;
        cfg_data  <= 16'($urandom);
        @(posedge clk);
        cfg_index <= CFG_SPARE_HI;
        cfg_data  <= 16'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // door model: the switch flips now and then, the door follows it one
    // sensor step at a time with random travel delays (long ones hit the
    // timeouts); a few ticks jump the door or carry random sensor noise
    task automatic run_door(input int n);
        int         target;
        int         r;
        logic [2:0] noise;
        repeat (n) begin
            if ($urandom_range(0, 24) == 0) cmd_lvl = !cmd_lvl;
            target = cmd_lvl ? POS_UP : POS_DOWN;
            if (door_pos != target) begin
                if (move_wait > 0) begin
                    move_wait--;
                end else begin
                    door_pos += (target > door_pos) ? 1 : -1;
                    move_wait = ($urandom_range(0, 5) == 0) ? $urandom_range(6, 24)
                                                            : $urandom_range(0, 3);
                end
            end
            r = $urandom_range(0, 99);
            if (r < 3) door_pos = $urandom_range(POS_DOWN, POS_UP);
            if (r >= 94) begin
                noise = 3'($urandom);
                send_tick(noise[2], noise[1], noise[0]);
            end else begin
                // bottom: both low, middle: down high, top: both high
                send_tick(cmd_lvl, door_pos == POS_UP, door_pos != POS_DOWN);
            end
        end
    endtask

    // stimulus
    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on the reset tick values
        send_tick(1'b0, 1'b0, 1'b0);  // no change at all
        send_tick(1'b0, 1'b0, 1'b1);  // moving up while unknown, ignored
        send_tick(1'b0, 1'b0, 1'b0);  // door is down, unknown to closed
        send_tick(1'b1, 1'b0, 1'b0);  // open: push coil, opening lamp on
        send_tick(1'b1, 1'b0, 1'b1);  // motion seen, timer rearmed
        send_tick(1'b1, 1'b1, 1'b1);  // door is up, opened
        send_tick(1'b0, 1'b1, 1'b1);  // close: pull coil, closing lamp on
        send_tick(1'b0, 1'b0, 1'b1);  // moving down, timer rearmed
        send_tick(1'b0, 1'b0, 1'b0);  // door is down, closed
        send_tick(1'b1, 1'b1, 1'b1);  // open and up in one tick, up wins over down
        send_tick(1'b0, 1'b0, 1'b0);  // close and moving down, down fall dropped
        wait_idle();

        // shortest timers, written while the closing timer is still running
        load_ticks(16'd1, 16'd2);
        send_tick(1'b0, 1'b0, 1'b1);  // moving up while closing, ignored
        send_tick(1'b0, 1'b0, 1'b0);  // door is down, closed
        send_tick(1'b1, 1'b0, 1'b0);  // open, armed for one tick
        send_tick(1'b1, 1'b0, 1'b0);  // opening timeout, lamp blinks
        send_tick(1'b1, 1'b1, 1'b0);  // is up from unknown, blink kept
        send_tick(1'b0, 1'b1, 1'b0);  // close, armed for one tick
        send_tick(1'b0, 1'b1, 1'b0);  // closing timeout
        send_tick(1'b0, 1'b0, 1'b0);  // moving down while unknown, ignored
        send_tick(1'b0, 1'b0, 1'b1);  // moving up while unknown, ignored
        send_tick(1'b0, 1'b0, 1'b0);  // door is down, closed
        send_tick(1'b1, 1'b0, 1'b1);  // open and motion in one tick
        send_tick(1'b1, 1'b0, 1'b1);  // finish timer counts
        send_tick(1'b1, 1'b0, 1'b1);  // finish timer expires
        send_tick(1'b1, 1'b1, 1'b1);  // is up, opened
        wait_idle();

        // random door traffic across several timer settings
        load_ticks(16'd0, 16'd0);  // zero acts like one tick
        run_door(PHASE_ITEMS);
        wait_idle();
        load_ticks(16'd1, 16'd1);
        run_door(PHASE_ITEMS);
        wait_idle();
        load_ticks(16'hFFFF, 16'hFFFF);  // never expires here
        run_door(PHASE_ITEMS);
        wait_idle();
        load_ticks(16'd4, 16'd9);
        run_door(PHASE_ITEMS);
        wait_idle();
        load_ticks(16'($urandom_range(1, 12)), 16'($urandom_range(1, 20)));
        run_door(PHASE_ITEMS);
        wait_idle();
        load_ticks(MOVE_START_RESET, MOVE_FINISH_RESET);
        run_door(PHASE_ITEMS);
        wait_idle();

        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // result side: random stalls and bursts, plus one long hold-off once the
    // sender has got going so both queues fill and full backs up the input
    initial begin
        int stall;
        int burst;
        bit held_once;
        held_once = 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            if (!held_once && sent_count >= HOLD_AT) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                held_once = 1'b1;
            end else begin
                if ($urandom_range(0, 9) == 0) rx_calm = !rx_calm;
                stall = pick_gap(rx_calm);
                if (stall > 0) begin
                    pop <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                pop <= 1'b1;
                burst = $urandom_range(1, 8);
                repeat (burst) @(posedge clk);
            end
        end
    end

    // watchdog on cycles where no request moves on either side
    always @(posedge clk) begin
        if (!rst_n) begin
            idle_cycles <= 0;
        end else if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

FILE: filelist.f
rtl/core/das_pkg.sv
rtl/core/das_front.sv
rtl/core/das_evq.sv
rtl/core/das_back.sv
rtl/core/door_actuator_sequencer_core.sv
dv/das_tick_checker.sv
dv/tb_top.sv
